// File: rtl/dtfd_pkg.sv
package dtfd_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COUNT_WIDTH    = 16;
  localparam int DEB_WIDTH      = 16;
  localparam int HYST_WIDTH     = 15;
  localparam int FID_WIDTH      = 6;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = (SAMPLE_WIDTH > DEB_WIDTH) ? SAMPLE_WIDTH : DEB_WIDTH;
  localparam int REL_WIDTH      =
    ((SAMPLE_WIDTH > HYST_WIDTH) ? SAMPLE_WIDTH : HYST_WIDTH + 1) + 1;
  localparam int CMP_WIDTH      = (COUNT_WIDTH > DEB_WIDTH) ? COUNT_WIDTH : DEB_WIDTH;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_THRESHOLD      = 3'd0,
    REG_HYSTERESIS     = 3'd1,
    REG_COMPARE_MODE   = 3'd2,
    REG_FAULT_INDEX    = 3'd3,
    REG_SET_DEBOUNCE   = 3'd4,
    REG_CLEAR_DEBOUNCE = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic {
    MODE_OVER  = 1'b0,
    MODE_UNDER = 1'b1
  } compare_mode_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] threshold;
    logic [HYST_WIDTH-1:0]          hysteresis;
    logic                           compare_mode;
    logic [FID_WIDTH-1:0]           fault_index;
    logic [DEB_WIDTH-1:0]           set_debounce;
    logic [DEB_WIDTH-1:0]           clear_debounce;
  } cfg_t;

  typedef struct packed {
    logic                 fault_active;
    logic                 set_event;
    logic                 clear_event;
    logic [FID_WIDTH-1:0] fault_id;
  } res_t;

endpackage

// File: rtl/dtfd_if.sv
interface dtfd_cfg_if;
  import dtfd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface dtfd_in_if;
  import dtfd_pkg::*;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  modport source (output valid, opcode, sample, input ready);
  modport sink (input valid, opcode, sample, output ready);
endinterface

interface dtfd_out_if;
  import dtfd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 fault_active;
  logic                 set_event;
  logic                 clear_event;
  logic [FID_WIDTH-1:0] fault_id;
  modport source (output valid, fault_active, set_event, clear_event, fault_id,
                  input ready);
  modport sink (input valid, fault_active, set_event, clear_event, fault_id,
                output ready);
endinterface

// File: rtl/debounced_threshold_fault_detector.sv
// debounced threshold fault detector
//
// cfg: register write channel, always ready; index selects threshold,
// hysteresis, compare mode, fault index, set debounce, clear debounce.
// writes beyond the register list are dropped. write only while idle.
// din: one word per sample (opcode evaluate or clear, signed sample).
// dout: one word per din word with fault flag, set/clear event pulses
// and the configured fault id.
// a word accepted on din moves through the input register, then compare and
// debounce update into the result register, which offers it on dout.
// throughput: one word per cycle unless dout stalls; the flag and counters
// update in the same cycle a word enters the result register, so consecutive words see it.
// when dout stalls the result register holds, the input register fills,
// and din.ready drops only once both are occupied.
// reset clears the config registers, counters and the flag (no fault), and empties
// both stages.
module debounced_threshold_fault_detector (
  input logic        clk,
  input logic        rst,
  dtfd_cfg_if.sink   cfg,
  dtfd_in_if.sink    din,
  dtfd_out_if.source dout
);
  import dtfd_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t out_res;

  logic                           s1_valid;
  logic                           s1_opcode;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic                           out_valid;
  logic                           advance;
  logic                           fire;

  assign cfg.ready = 1'b1;

  dtfd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  assign advance  = !out_valid || dout.ready;
  assign fire     = s1_valid && advance;
  assign din.ready = !s1_valid || advance;

  dtfd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_q),
    .fire   (fire),
    .opcode (s1_opcode),
    .sample (s1_sample),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (din.ready) begin
        s1_valid <= din.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_opcode <= din.opcode;
      s1_sample <= din.sample;
    end
    if (fire) begin
      out_res <= res;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.fault_active = out_res.fault_active;
  assign dout.set_event    = out_res.set_event;
  assign dout.clear_event  = out_res.clear_event;
  assign dout.fault_id     = out_res.fault_id;

endmodule

// File: rtl/dtfd_cfg_regs.sv
module dtfd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [dtfd_pkg::CFG_IDX_WIDTH-1:0]  wr_index,
  input  logic [dtfd_pkg::CFG_DATA_WIDTH-1:0] wr_data,
  output dtfd_pkg::cfg_t                      cfg
);
  import dtfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THRESHOLD:      cfg.threshold      <= wr_data[SAMPLE_WIDTH-1:0];
        REG_HYSTERESIS:     cfg.hysteresis     <= wr_data[HYST_WIDTH-1:0];
        REG_COMPARE_MODE:   cfg.compare_mode   <= wr_data[0];
        REG_FAULT_INDEX:    cfg.fault_index    <= wr_data[FID_WIDTH-1:0];
        REG_SET_DEBOUNCE:   cfg.set_debounce   <= wr_data[DEB_WIDTH-1:0];
        REG_CLEAR_DEBOUNCE: cfg.clear_debounce <= wr_data[DEB_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/dtfd_core.sv
module dtfd_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dtfd_pkg::cfg_t                        cfg,
  input  logic                                  fire,
  input  logic                                  opcode,
  input  logic signed [dtfd_pkg::SAMPLE_WIDTH-1:0] sample,
  output dtfd_pkg::res_t                        res
);
  import dtfd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] trip_count, trip_count_next;
  logic [COUNT_WIDTH-1:0] release_count, release_count_next;
  logic                   flag, flag_next;

  logic signed [REL_WIDTH-1:0] s_ext, thr_ext, hyst_ext, rel_lo, rel_hi;
  logic                        tripped, released;
  logic [COUNT_WIDTH-1:0]      trip_inc, release_inc;
  logic                        set_ev, clr_ev;

  assign s_ext    = REL_WIDTH'(sample);
  assign thr_ext  = REL_WIDTH'(cfg.threshold);
  assign hyst_ext = REL_WIDTH'(cfg.hysteresis);
  assign rel_lo   = thr_ext - hyst_ext;
  assign rel_hi   = thr_ext + hyst_ext;

  assign tripped  = (cfg.compare_mode == MODE_OVER) ? (s_ext >= thr_ext) : (s_ext <= thr_ext);
  assign released = (cfg.compare_mode == MODE_OVER) ? (s_ext < rel_lo) : (s_ext > rel_hi);

  assign trip_inc    = (trip_count == COUNT_MAX) ? COUNT_MAX : trip_count + 1'b1;
  assign release_inc = (release_count == COUNT_MAX) ? COUNT_MAX : release_count + 1'b1;

  always_comb begin
    trip_count_next    = trip_count;
    release_count_next = release_count;
    flag_next          = flag;
    set_ev             = 1'b0;
    clr_ev             = 1'b0;
    if (opcode == OP_CLEAR) begin
      trip_count_next    = '0;
      release_count_next = '0;
      flag_next          = 1'b0;
    end else if (tripped) begin
      release_count_next = '0;
      if (!flag) begin
        if (CMP_WIDTH'(trip_inc) >= CMP_WIDTH'(cfg.set_debounce)) begin
          flag_next       = 1'b1;
          trip_count_next = '0;
          set_ev          = 1'b1;
        end else begin
          trip_count_next = trip_inc;
        end
      end
    end else if (released) begin
      trip_count_next = '0;
      if (flag) begin
        if (CMP_WIDTH'(release_inc) >= CMP_WIDTH'(cfg.clear_debounce)) begin
          flag_next          = 1'b0;
          release_count_next = '0;
          clr_ev             = 1'b1;
        end else begin
          release_count_next = release_inc;
        end
      end
    end else begin
      trip_count_next    = '0;
      release_count_next = '0;
    end
  end

  always_comb begin
    res.fault_active = flag_next;
    res.set_event    = set_ev;
    res.clear_event  = clr_ev;
    res.fault_id     = cfg.fault_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trip_count    <= '0;
      release_count <= '0;
      flag          <= 1'b0;
    end else if (fire) begin
      trip_count    <= trip_count_next;
      release_count <= release_count_next;
      flag          <= flag_next;
    end
  end

endmodule

// File: test/tb_debounced_threshold_fault_detector.sv
module tb_debounced_threshold_fault_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import dtfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int SAMPLE_MIN     = -(2 ** (SAMPLE_WIDTH - 1));
  localparam int SAMPLE_MAX     = (2 ** (SAMPLE_WIDTH - 1)) - 1;
  localparam logic [COUNT_WIDTH-1:0]   COUNT_TOP   = '1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtfd_cfg_if cfg_bus ();
  dtfd_in_if  sample_bus ();
  dtfd_out_if result_bus ();

  debounced_threshold_fault_detector dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_bus),
    .din  (sample_bus),
    .dout (result_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow registers and detector state
  logic signed [SAMPLE_WIDTH-1:0] thr_reg;
  logic [HYST_WIDTH-1:0]          hyst_reg;
  compare_mode_t                  mode_reg;
  logic [FID_WIDTH-1:0]           fid_reg;
  logic [DEB_WIDTH-1:0]           set_deb_reg;
  logic [DEB_WIDTH-1:0]           clr_deb_reg;
  logic [COUNT_WIDTH-1:0]         trip_run;
  logic [COUNT_WIDTH-1:0]         release_run;
  logic                           fault_flag;

  res_t expected_words[$];
  int   errors       = 0;
  int   quiet_cycles = 0;
  int   idle_pct     = 20;
  int   stall_left   = 0;

  initial begin
    thr_reg     = '0;
    hyst_reg    = '0;
    mode_reg    = MODE_OVER;
    fid_reg     = '0;
    set_deb_reg = '0;
    clr_deb_reg = '0;
    trip_run    = '0;
    release_run = '0;
    fault_flag  = 1'b0;
  end

  function automatic void write_register(logic [CFG_IDX_WIDTH-1:0] idx,
                                         logic [CFG_DATA_WIDTH-1:0] val);
    case (idx)
      REG_THRESHOLD:      thr_reg = val[SAMPLE_WIDTH-1:0];
      REG_HYSTERESIS:     hyst_reg = val[HYST_WIDTH-1:0];
      REG_COMPARE_MODE:   mode_reg = compare_mode_t'(val[0]);
      REG_FAULT_INDEX:    fid_reg = val[FID_WIDTH-1:0];
      REG_SET_DEBOUNCE:   set_deb_reg = val[DEB_WIDTH-1:0];
      REG_CLEAR_DEBOUNCE: clr_deb_reg = val[DEB_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  function automatic res_t detect(opcode_t op, logic signed [SAMPLE_WIDTH-1:0] s);
    res_t r;
    int   thr_i;
    int   smp;
    logic tripped;
    logic released;
    r = '0;
    if (op == OP_CLEAR) begin
      trip_run    = '0;
      release_run = '0;
      fault_flag  = 1'b0;
    end else begin
      thr_i = thr_reg;
      smp   = s;
      if (mode_reg == MODE_OVER) begin
        tripped  = smp >= thr_i;
        released = smp < thr_i - int'(hyst_reg);
      end else begin
        tripped  = smp <= thr_i;
        released = smp > thr_i + int'(hyst_reg);
      end
      if (tripped) begin
        release_run = '0;
        if (!fault_flag) begin
          trip_run = bump(trip_run);
          if (trip_run >= set_deb_reg) begin
            fault_flag  = 1'b1;
            trip_run    = '0;
            r.set_event = 1'b1;
          end
        end
      end else if (released) begin
        trip_run = '0;
        if (fault_flag) begin
          release_run = bump(release_run);
          if (release_run >= clr_deb_reg) begin
            fault_flag    = 1'b0;
            release_run   = '0;
            r.clear_event = 1'b1;
          end
        end
      end else begin
        trip_run    = '0;
        release_run = '0;
      end
    end
    r.fault_active = fault_flag;
    r.fault_id     = fid_reg;
    return r;
  endfunction

  // result check, prediction and watchdog, all on the same edge
  always @(posedge clk) begin
    res_t want;
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (result_bus.valid && result_bus.ready) begin
        moved = 1'b1;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, expected none, got fa=%0b se=%0b ce=%0b id=%0d",
                   $time, result_bus.fault_active, result_bus.set_event,
                   result_bus.clear_event, result_bus.fault_id);
        end else begin
          want = expected_words.pop_front();
          if (result_bus.fault_active !== want.fault_active ||
              result_bus.set_event !== want.set_event ||
              result_bus.clear_event !== want.clear_event ||
              result_bus.fault_id !== want.fault_id) begin
            errors++;
            $display("%0t: result mismatch, expected fa=%0b se=%0b ce=%0b id=%0d, got fa=%0b se=%0b ce=%0b id=%0d",
                     $time, want.fault_active, want.set_event, want.clear_event,
                     want.fault_id, result_bus.fault_active, result_bus.set_event,
                     result_bus.clear_event, result_bus.fault_id);
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        write_register(cfg_bus.index, cfg_bus.data);
      end
      if (sample_bus.valid && sample_bus.ready) begin
        moved = 1'b1;
        expected_words.push_back(detect(opcode_t'(sample_bus.opcode), sample_bus.sample));
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb_debounced_threshold_fault_detector: errors");
          $finish;
        end
      end
    end
  end

  // receiver drops ready in random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      result_bus.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  task automatic send_word(opcode_t op, logic signed [SAMPLE_WIDTH-1:0] s);
    if ($urandom_range(0, 99) < idle_pct) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        sample_bus.valid <= 1'b0;
      end
    end
    @(negedge clk);
    sample_bus.valid  <= 1'b1;
    sample_bus.opcode <= op;
    sample_bus.sample <= s;
    do @(posedge clk); while (!sample_bus.ready);
  endtask

  task automatic park_input;
    @(negedge clk);
    sample_bus.valid <= 1'b0;
  endtask

  task automatic wait_results;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic settle;
    park_input();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_in(int lo, int hi);
    if (lo < SAMPLE_MIN) lo = SAMPLE_MIN;
    if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
    if (lo > hi) return SAMPLE_WIDTH'($urandom);
    case ($urandom_range(0, 7))
      0:       return SAMPLE_WIDTH'(lo);
      1:       return SAMPLE_WIDTH'(hi);
      default: return SAMPLE_WIDTH'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  function automatic logic [DEB_WIDTH-1:0] pick_debounce();
    case ($urandom_range(0, 19))
      0:       return '1;
      1:       return DEB_WIDTH'($urandom_range(7, 65534));
      default: return DEB_WIDTH'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_word(OP_EVAL, 16'sd0);
    send_word(OP_EVAL, -16'sd1);
    send_word(OP_EVAL, 16'sh7FFF);
    send_word(OP_EVAL, 16'sh8000);
    send_word(OP_EVAL, 16'sh7FFF);
    send_word(OP_CLEAR, 16'sh8000);
  endtask

  task automatic test_over_hysteresis;
    settle();
    write_reg(REG_THRESHOLD, 16'd100);
    write_reg(REG_HYSTERESIS, 16'd20);
    write_reg(REG_COMPARE_MODE, 16'(MODE_OVER));
    write_reg(REG_FAULT_INDEX, 16'h003F);
    write_reg(REG_SET_DEBOUNCE, 16'd3);
    write_reg(REG_CLEAR_DEBOUNCE, 16'd2);
    send_word(OP_EVAL, 16'sd100);
    send_word(OP_EVAL, 16'sd150);
    send_word(OP_EVAL, 16'sd85);
    send_word(OP_EVAL, 16'sd100);
    send_word(OP_EVAL, 16'sd101);
    send_word(OP_EVAL, 16'sh7FFF);
    send_word(OP_EVAL, 16'sd100);
    send_word(OP_EVAL, 16'sd79);
    send_word(OP_EVAL, 16'sd80);
    send_word(OP_EVAL, 16'sd79);
    send_word(OP_EVAL, 16'sh8000);
  endtask

  task automatic test_under_mode;
    settle();
    write_reg(REG_THRESHOLD, -16'sd100);
    write_reg(REG_HYSTERESIS, 16'hFFFF);
    write_reg(REG_COMPARE_MODE, 16'(MODE_UNDER));
    write_reg(REG_FAULT_INDEX, 16'hFFC0);
    write_reg(REG_SET_DEBOUNCE, 16'd1);
    write_reg(REG_CLEAR_DEBOUNCE, 16'd0);
    send_word(OP_EVAL, 16'sh8000);
    send_word(OP_EVAL, 16'sd32667);
    send_word(OP_EVAL, 16'sh7FFF);
    send_word(OP_EVAL, -16'sd100);
    send_word(OP_CLEAR, 16'sh7FFF);
  endtask

  task automatic test_debounce_limits;
    settle();
    write_reg(REG_THRESHOLD, 16'h8000);
    write_reg(REG_HYSTERESIS, 16'h0000);
    write_reg(REG_COMPARE_MODE, 16'(MODE_OVER));
    write_reg(REG_SET_DEBOUNCE, 16'hFFFF);
    write_reg(REG_CLEAR_DEBOUNCE, 16'hFFFF);
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'hA5A5);
    repeat (3) send_word(OP_EVAL, SAMPLE_WIDTH'($urandom));
  endtask

  task automatic random_phase(int n_words, bit drain_midway);
    logic signed [SAMPLE_WIDTH-1:0] thr;
    logic [HYST_WIDTH-1:0]          hyst;
    compare_mode_t                  mode;
    int thr_i, h_i, run, region, sent;
    int trip_lo, trip_hi, rel_lo, rel_hi, dead_lo, dead_hi;
    settle();
    case ($urandom_range(0, 5))
      0:       thr = 16'sh7FFF;
      1:       thr = 16'sh8000;
      default: thr = SAMPLE_WIDTH'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       hyst = '0;
      1:       hyst = '1;
      default: hyst = HYST_WIDTH'($urandom_range(0, 300));
    endcase
    mode = compare_mode_t'($urandom_range(0, 1));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_HYSTERESIS, {1'($urandom), hyst});
    write_reg(REG_COMPARE_MODE, {15'($urandom), 1'(mode)});
    write_reg(REG_FAULT_INDEX, 16'($urandom));
    write_reg(REG_SET_DEBOUNCE, pick_debounce());
    write_reg(REG_CLEAR_DEBOUNCE, pick_debounce());
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));

    thr_i = thr;
    h_i   = hyst;
    if (mode == MODE_OVER) begin
      trip_lo = thr_i;             trip_hi = SAMPLE_MAX;
      rel_lo  = SAMPLE_MIN;        rel_hi  = thr_i - h_i - 1;
      dead_lo = thr_i - h_i;       dead_hi = thr_i - 1;
    end else begin
      trip_lo = SAMPLE_MIN;        trip_hi = thr_i;
      rel_lo  = thr_i + h_i + 1;   rel_hi  = SAMPLE_MAX;
      dead_lo = thr_i + 1;         dead_hi = thr_i + h_i;
    end

    sent = 0;
    while (sent < n_words) begin
      region = $urandom_range(0, 9);
      run = (region < 2) ? 1 : $urandom_range(1, 8);
      repeat (run) begin
        case (region)
          0:       send_word(OP_CLEAR, SAMPLE_WIDTH'($urandom));
          1:       send_word(OP_EVAL, SAMPLE_WIDTH'($urandom));
          2, 3:    send_word(OP_EVAL, pick_in(dead_lo, dead_hi));
          4, 5, 6: send_word(OP_EVAL, pick_in(trip_lo, trip_hi));
          default: send_word(OP_EVAL, pick_in(rel_lo, rel_hi));
        endcase
        sent++;
        if (drain_midway && sent == n_words / 2) begin
          park_input();
          wait_results();
        end
      end
    end
  endtask

  task automatic test_random_traffic;
    for (int p = 0; p < 8; p++) begin
      if (p == 2 || p == 7) idle_pct = 0;
      else idle_pct = $urandom_range(10, 35);
      random_phase(130, p == 3);
    end
  endtask

  initial begin
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_THRESHOLD;
    cfg_bus.data      = '0;
    sample_bus.valid  = 1'b0;
    sample_bus.opcode = OP_EVAL;
    sample_bus.sample = '0;
    result_bus.ready  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_over_hysteresis();
    test_under_mode();
    test_debounce_limits();
    test_random_traffic();
    settle();

    if (errors == 0) begin
      $display("tb_debounced_threshold_fault_detector: clean");
    end else begin
      $display("tb_debounced_threshold_fault_detector: errors");
    end
    $finish;
  end

endmodule
